/* rtl/peqd_pkg.sv */
// ----------------------------------------------------------------------------
// peqd_pkg
// Shared types and constants of the priority event queue dispatcher.
// ----------------------------------------------------------------------------
package peqd_pkg;

	localparam logic [2:0] ST_POSTED     = 3'd0;
	localparam logic [2:0] ST_POOL_FULL  = 3'd1;
	localparam logic [2:0] ST_TASK_OFF   = 3'd2;
	localparam logic [2:0] ST_DISPATCHED = 3'd3;
	localparam logic [2:0] ST_DROPPED    = 3'd4;
	localparam logic [2:0] ST_IDLE_COUNT = 3'd5;
	localparam logic [2:0] ST_IDLE_DONE  = 3'd6;

	localparam logic OP_POST     = 1'b0;
	localparam logic OP_DISPATCH = 1'b1;

	localparam logic CFG_TASK_ENABLE = 1'b0;
	localparam logic CFG_IDLE_LIMIT  = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage

/* rtl/peqd_ctrl.sv */
// ----------------------------------------------------------------------------
// peqd_ctrl
// Sequencer: capture a word, execute it, hold the result until taken.
// ----------------------------------------------------------------------------
module peqd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output peqd_pkg::dp_cmd_t   cmd
);

	peqd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= peqd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd.load  = 1'b0;
		cmd.exec  = 1'b0;
		case (state_q)
			peqd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = peqd_pkg::S_EXEC;
				end
			end
			peqd_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = peqd_pkg::S_OUT;
			end
			peqd_pkg::S_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = peqd_pkg::S_EXEC;
					end else begin
						state_d = peqd_pkg::S_IDLE;
					end
				end
			end
			default: state_d = peqd_pkg::S_IDLE;
		endcase
	end

endmodule

/* rtl/peqd_dp.sv */
// ----------------------------------------------------------------------------
// peqd_dp
// Datapath: slot pool, free bitmaps, priority queues and idle counter.
// ----------------------------------------------------------------------------
module peqd_dp #(
	parameter int NUM_PRIORITIES = 8,
	parameter int POOL_SLOTS     = 64,
	parameter int NUM_TASKS      = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  peqd_pkg::dp_cmd_t cmd,
	input  logic [71:0]       in_word,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output logic [70:0]       out_word,
	output logic [2:0]        out_prio
);

	localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
	localparam int CW = 7;

	logic [15:0] task_en_q;
	logic [31:0] idle_limit_q;
	logic [31:0] idle_cnt_q;
	logic [7:0]  slot_free_q [8];
	logic [7:0]  group_free_q;
	logic [5:0]  head_q [NUM_PRIORITIES];
	logic [5:0]  tail_q [NUM_PRIORITIES];
	logic [CW-1:0] count_q [NUM_PRIORITIES];

	logic [31:0] pool_event [64];
	logic [31:0] pool_msg [64];
	logic [3:0]  pool_task [64];
	logic [5:0]  pool_next [64];

	logic        op_q;
	logic [3:0]  task_q;
	logic [2:0]  prio_q;
	logic [31:0] ev_q, msg_q;
	logic [70:0] out_q;
	logic [70:0] out_d;
	logic [2:0]  oprio_q;

	logic [31:0] rd_event_q;
	logic [31:0] rd_msg_q;
	logic [3:0]  rd_task_q;
	logic [5:0]  rd_next_q;

	function automatic logic [2:0] low8(input logic [7:0] v);
		logic [2:0] r;
		r = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) r = 3'(i);
		end
		return r;
	endfunction

	logic       t_en;
	logic [2:0] g, s;
	logic [5:0] slot;
	logic       full;
	logic [PW-1:0] pq;
	logic       any;
	logic [PW-1:0] dp;
	logic [5:0] hslot;

	always_comb begin
		t_en = (32'(task_q) < 32'(NUM_TASKS)) && task_en_q[task_q];
		g    = low8(group_free_q);
		s    = low8(slot_free_q[g]);
		slot = {g, s};
		full = (group_free_q == 8'd0) || (32'(slot) >= 32'(POOL_SLOTS))
			|| (slot_free_q[g] == 8'd0);
		if (32'(prio_q) >= 32'(NUM_PRIORITIES)) pq = PW'(NUM_PRIORITIES - 1);
		else pq = PW'(prio_q);
		any = 1'b0;
		dp  = '0;
		for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
			if (count_q[p] != '0) begin
				any = 1'b1;
				dp  = PW'(p);
			end
		end
		hslot = head_q[dp];
	end

	// The head of the lowest non-empty queue is read while the word is captured.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= in_word[0];
			task_q     <= in_word[4:1];
			prio_q     <= in_word[7:5];
			ev_q       <= in_word[39:8];
			msg_q      <= in_word[71:40];
			rd_event_q <= pool_event[hslot];
			rd_msg_q   <= pool_msg[hslot];
			rd_task_q  <= pool_task[hslot];
			rd_next_q  <= pool_next[hslot];
		end
	end

	wire do_post = cmd.exec && op_q == peqd_pkg::OP_POST && t_en && !full;
	wire do_pop  = cmd.exec && op_q == peqd_pkg::OP_DISPATCH && any;

	always_ff @(posedge clk) begin
		if (do_post) begin
			pool_event[slot] <= ev_q;
			pool_msg[slot]   <= msg_q;
			pool_task[slot]  <= task_q;
			if (count_q[pq] != '0) pool_next[tail_q[pq]] <= slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_en_q    <= 16'hFFFF;
			idle_limit_q <= '0;
			idle_cnt_q   <= '0;
			group_free_q <= 8'hFF;
			for (int i = 0; i < 8; i++) slot_free_q[i] <= 8'hFF;
			for (int p = 0; p < NUM_PRIORITIES; p++) begin
				head_q[p]  <= '0;
				tail_q[p]  <= '0;
				count_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == peqd_pkg::CFG_TASK_ENABLE) task_en_q <= cfg_data[15:0];
				else idle_limit_q <= cfg_data;
			end
			if (do_post) begin
				slot_free_q[g][s] <= 1'b0;
				if (slot_free_q[g] == (8'd1 << s)) group_free_q[g] <= 1'b0;
				if (count_q[pq] == '0) head_q[pq] <= slot;
				tail_q[pq]  <= slot;
				count_q[pq] <= count_q[pq] + 1'b1;
			end
			if (do_pop) begin
				head_q[dp]  <= rd_next_q;
				count_q[dp] <= count_q[dp] - 1'b1;
				slot_free_q[hslot[5:3]][hslot[2:0]] <= 1'b1;
				group_free_q[hslot[5:3]] <= 1'b1;
				idle_cnt_q <= '0;
			end else if (cmd.exec && op_q == peqd_pkg::OP_DISPATCH
					&& idle_cnt_q < idle_limit_q) begin
				idle_cnt_q <= idle_cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		out_d = '0;
		if (op_q == peqd_pkg::OP_POST) begin
			if (!t_en) out_d[2:0] = peqd_pkg::ST_TASK_OFF;
			else if (full) out_d[2:0] = peqd_pkg::ST_POOL_FULL;
			else out_d[2:0] = peqd_pkg::ST_POSTED;
		end else if (any) begin
			out_d[2:0] = (32'(rd_task_q) < 32'(NUM_TASKS) && task_en_q[rd_task_q])
				? peqd_pkg::ST_DISPATCHED : peqd_pkg::ST_DROPPED;
			out_d[6:3]   = rd_task_q;
			out_d[38:7]  = rd_event_q;
			out_d[70:39] = rd_msg_q;
		end else begin
			out_d[2:0] = (idle_cnt_q < idle_limit_q)
				? peqd_pkg::ST_IDLE_COUNT : peqd_pkg::ST_IDLE_DONE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_q   <= out_d;
			oprio_q <= (op_q == peqd_pkg::OP_DISPATCH && any) ? 3'(dp) : 3'd0;
		end
	end

	assign out_word = out_q;
	assign out_prio = oprio_q;

endmodule

/* rtl/priority_event_queue_dispatcher.sv */
// Each accepted word passes the capture and execute steps of the sequencer before
// its result word is offered; no new word is accepted before that result is taken.
// The pool is read in the capture step and written in the execute step.
// Reset: asynchronous; all slots free, queues empty, idle count zero,
// task enable mask all ones and idle limit zero.
// ----------------------------------------------------------------------------
// priority_event_queue_dispatcher
// Event pool with eight priority queues, posted to and dispatched from a stream.
// ----------------------------------------------------------------------------
module priority_event_queue_dispatcher #(
	parameter int NUM_PRIORITIES = 8,
	parameter int POOL_SLOTS     = 64,
	parameter int NUM_TASKS      = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// opcode, task_id, priority_req, event_code, message_handle
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, out_task, out_event, out_message, out_priority
	output logic [79:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	peqd_pkg::dp_cmd_t cmd;
	logic [70:0] word;
	logic [2:0]  prio;

	assign cfg_ready = 1'b1;

	peqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	peqd_dp #(
		.NUM_PRIORITIES (NUM_PRIORITIES),
		.POOL_SLOTS     (POOL_SLOTS),
		.NUM_TASKS      (NUM_TASKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_word   (s_tdata),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (word),
		.out_prio  (prio)
	);

	assign m_tdata = {6'd0, prio, word};

endmodule

/* tb/priority_event_queue_dispatcher_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_event_queue_dispatcher_test
// Streams post and dispatch words into the dispatcher under random bursts and
// output stalls, predicts each result word from a behavioral copy of the pool,
// the eight priority queues and the idle counter, and compares field by field.
// ----------------------------------------------------------------------------
module priority_event_queue_dispatcher_test;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  owner;
		logic [31:0] ev;
		logic [31:0] msg;
		logic [2:0]  prio;
	} outcome_t;

	localparam int IDLE_CYCLE_LIMIT = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	priority_event_queue_dispatcher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	logic [71:0] pending_words[$];
	outcome_t    expected_results[$];
	int          error_count;
	int          quiet_cycles;

	// Behavioral copy of the dispatcher state.
	logic [15:0] enable_mask;
	logic [31:0] idle_limit_reg;
	logic [31:0] idle_count;
	logic [31:0] pool_ev[64];
	logic [31:0] pool_msg[64];
	logic [3:0]  pool_owner[64];
	logic [5:0]  pool_link[64];
	logic [7:0]  slot_free[8];
	logic [7:0]  group_free;
	logic [5:0]  q_head[8];
	logic [5:0]  q_tail[8];
	logic [6:0]  q_depth[8];

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [71:0] pack_word(logic op, logic [3:0] owner, logic [2:0] prio,
			logic [31:0] ev, logic [31:0] msg);
		return {msg, ev, prio, owner, op};
	endfunction

	task automatic predict_dispatcher(input logic [71:0] w);
		outcome_t r;
		logic     op;
		logic [3:0] owner;
		logic [2:0] prio;
		int g;
		int s;
		int slot;
		bit found;
		op = w[0];
		owner = w[4:1];
		prio = w[7:5];
		r = '0;
		found = 1'b0;
		if (op == peqd_pkg::OP_POST) begin
			if (!enable_mask[owner]) begin
				r.status = peqd_pkg::ST_TASK_OFF;
			end else if (group_free == 8'h00) begin
				r.status = peqd_pkg::ST_POOL_FULL;
			end else begin
				g = 0;
				while (!group_free[g]) g++;
				s = 0;
				while (!slot_free[g][s]) s++;
				slot = g * 8 + s;
				slot_free[g][s] = 1'b0;
				if (slot_free[g] == 8'h00) group_free[g] = 1'b0;
				pool_ev[slot] = w[39:8];
				pool_msg[slot] = w[71:40];
				pool_owner[slot] = owner;
				pool_link[slot] = '0;
				if (q_depth[prio] == 0) q_head[prio] = slot[5:0];
				else pool_link[q_tail[prio]] = slot[5:0];
				q_tail[prio] = slot[5:0];
				q_depth[prio] = q_depth[prio] + 7'd1;
				r.status = peqd_pkg::ST_POSTED;
			end
		end else begin
			for (int p = 0; p < 8; p++) begin
				if (!found && q_depth[p] != 0) begin
					found = 1'b1;
					slot = q_head[p];
					q_head[p] = pool_link[slot];
					q_depth[p] = q_depth[p] - 7'd1;
					slot_free[slot / 8][slot % 8] = 1'b1;
					group_free[slot / 8] = 1'b1;
					idle_count = '0;
					r.status = enable_mask[pool_owner[slot]]
						? peqd_pkg::ST_DISPATCHED : peqd_pkg::ST_DROPPED;
					r.owner = pool_owner[slot];
					r.ev = pool_ev[slot];
					r.msg = pool_msg[slot];
					r.prio = p[2:0];
				end
			end
			if (!found) begin
				if (idle_count < idle_limit_reg) begin
					idle_count = idle_count + 32'd1;
					r.status = peqd_pkg::ST_IDLE_COUNT;
				end else begin
					r.status = peqd_pkg::ST_IDLE_DONE;
				end
			end
		end
		expected_results.push_back(r);
	endtask

	// Sender: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		logic        next_valid;
		logic [71:0] next_data;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			next_valid = s_tvalid;
			next_data = s_tdata;
			if (s_tvalid && s_tready) begin
				predict_dispatcher(s_tdata);
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_words.size() != 0) begin
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
					end
					if (gap_left == 0) begin
						burst_left--;
						next_valid = 1'b1;
						next_data = pending_words.pop_front();
						if (burst_left == 0) gap_left = $urandom_range(0, 5);
					end
				end
			end
			s_tvalid <= next_valid;
			s_tdata <= next_data;
		end
	end

	// Receiver: stall pattern is periodically redrawn at random.
	int stall_mode;
	int stall_phase;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode = 0;
			stall_phase = 0;
		end else begin
			stall_phase++;
			if (stall_phase % 40 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= 1'($urandom_range(0, 1));
				end
				2: begin
					m_tready <= (stall_phase % 4 == 0);
				end
				default: begin
					m_tready <= ($urandom_range(0, 9) == 0);
				end
			endcase
		end
	end

	// Result checker.
	always @(posedge clk) begin
		outcome_t want;
		outcome_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = m_tdata[2:0];
			got.owner = m_tdata[6:3];
			got.ev = m_tdata[38:7];
			got.msg = m_tdata[70:39];
			got.prio = m_tdata[73:71];
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					error_count++;
				end
				if (got.owner !== want.owner) begin
					$error("out_task expected %0d actual %0d", want.owner, got.owner);
					error_count++;
				end
				if (got.ev !== want.ev) begin
					$error("out_event expected %h actual %h", want.ev, got.ev);
					error_count++;
				end
				if (got.msg !== want.msg) begin
					$error("out_message expected %h actual %h", want.msg, got.msg);
					error_count++;
				end
				if (got.prio !== want.prio) begin
					$error("out_priority expected %0d actual %0d", want.prio, got.prio);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_CYCLE_LIMIT) begin
			$display("priority_event_queue_dispatcher_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_register(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == peqd_pkg::CFG_TASK_ENABLE) enable_mask = value[15:0];
		else idle_limit_reg = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results;
		do @(negedge clk);
		while (pending_words.size() != 0 || expected_results.size() != 0 || s_tvalid);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_random(input int count, input int post_pct);
		logic [31:0] msg;
		for (int i = 0; i < count; i++) begin
			msg = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
			if ($urandom_range(1, 100) <= post_pct)
				pending_words.push_back(pack_word(peqd_pkg::OP_POST,
					4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), $urandom, msg));
			else
				pending_words.push_back(pack_word(peqd_pkg::OP_DISPATCH,
					4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)), $urandom,
					$urandom));
		end
	endtask

	initial begin
		logic [31:0] limits[5];
		error_count = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = peqd_pkg::CFG_TASK_ENABLE;
		cfg_data = '0;
		enable_mask = 16'hFFFF;
		idle_limit_reg = '0;
		idle_count = '0;
		group_free = 8'hFF;
		for (int i = 0; i < 8; i++) begin
			slot_free[i] = 8'hFF;
			q_head[i] = '0;
			q_tail[i] = '0;
			q_depth[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty dispatch, field extremes, every priority, then drain.
		pending_words.push_back(pack_word(peqd_pkg::OP_DISPATCH, 4'h0, 3'd0, '0, '0));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'h0, 3'd0, 32'h0, 32'h0));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'hF, 3'd7, 32'hFFFFFFFF,
			32'hFFFFFFFF));
		for (int p = 6; p >= 1; p--)
			pending_words.push_back(pack_word(peqd_pkg::OP_POST, p[3:0], p[2:0], $urandom,
				$urandom));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'h5, 3'd0, 32'hA5A5A5A5,
			32'h5A5A5A5A));
		for (int i = 0; i < 10; i++)
			pending_words.push_back(pack_word(peqd_pkg::OP_DISPATCH, 4'hF, 3'd7, '1, '1));
		drain_results();

		// Disabled tasks: queue events, then disable some of their owners before dispatch.
		write_register(peqd_pkg::CFG_IDLE_LIMIT, 32'd2);
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'h3, 3'd2, 32'h11, 32'h0));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'hC, 3'd2, 32'h22, 32'h33));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'h4, 3'd1, 32'h44, 32'h55));
		drain_results();
		write_register(peqd_pkg::CFG_TASK_ENABLE, 32'h0000_0FF7);
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'hF, 3'd0, 32'h66, 32'h77));
		pending_words.push_back(pack_word(peqd_pkg::OP_POST, 4'h3, 3'd0, 32'h66, 32'h77));
		for (int i = 0; i < 6; i++)
			pending_words.push_back(pack_word(peqd_pkg::OP_DISPATCH, 4'h0, 3'd0, '0, '0));
		drain_results();

		// Random phases with changing configuration.
		limits[0] = 32'd0;
		limits[1] = 32'd1;
		limits[2] = 32'd5;
		limits[3] = 32'hFFFFFFFF;
		limits[4] = $urandom_range(0, 20);
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_register(peqd_pkg::CFG_TASK_ENABLE, 32'h0000_FFFF);
				1: write_register(peqd_pkg::CFG_TASK_ENABLE, 32'h0000_0000);
				default: write_register(peqd_pkg::CFG_TASK_ENABLE,
					($urandom_range(0, 1) != 0) ? 32'h0000_FFFF : $urandom);
			endcase
			write_register(peqd_pkg::CFG_IDLE_LIMIT, limits[ph % 5]);
			case (ph)
				0: queue_random(130, 85);
				1: queue_random(40, 50);
				2: queue_random(130, 30);
				3: queue_random(120, 90);
				4: queue_random(110, 55);
				default: queue_random(100, 40);
			endcase
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("priority_event_queue_dispatcher_test: PASS");
		end else begin
			$display("priority_event_queue_dispatcher_test: FAIL");
		end
		$finish;
	end

endmodule
